[hdl/cle_pkg.sv]
// cle_pkg: constants shared by the console line editor
// character codes, operation codes and echo kinds; no dependencies
package cle_pkg;

  localparam logic OP_RX   = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] ECHO_NONE  = 2'd0;
  localparam logic [1:0] ECHO_BYTE  = 2'd1;
  localparam logic [1:0] ECHO_ERASE = 2'd2;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_CTLD = 8'h04;
  localparam logic [7:0] CH_CTLH = 8'h08;
  localparam logic [7:0] CH_NL   = 8'h0a;
  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_CTLP = 8'h10;
  localparam logic [7:0] CH_CTLU = 8'h15;
  localparam logic [7:0] CH_DEL  = 8'h7f;

  localparam logic [9:0] ERASE_MAX = 10'h3ff;

endpackage

[hdl/console_line_editor_unit.sv]
// console_line_editor_unit: canonical line editor over a ring buffer
// depends on cle_pkg and cle_ram
//
//   channel  handshake            payload
//   in       start / busy         in_operation, in_rx_byte, in_read_started
//   out      out_valid (strobe)   out_echo_kind .. out_dump_request
//
// plain bytes, erase, control-p and reads of an empty buffer: result in the cycle after start
// a read of a committed byte: the registered ram read, then the result register
// kill line: scans back one entry per ram read, then strobes the result
// busy is high while a committed read or a kill is at work; each result strobes for one cycle
// and cannot be held off; reset clears the indices, the ram needs no clearing
module console_line_editor_unit #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic       in_read_started,
  output logic       out_valid,
  output logic [1:0] out_echo_kind,
  output logic [7:0] out_echo_byte,
  output logic [9:0] out_erase_count,
  output logic       out_read_valid,
  output logic [7:0] out_read_byte,
  output logic       out_read_done,
  output logic       out_line_ready,
  output logic       out_dump_request
);
  import cle_pkg::*;

  localparam int IW = $clog2(2 * BUFFER_DEPTH);
  localparam int AW = $clog2(BUFFER_DEPTH);
  localparam logic [IW-1:0] IDX_LAST = IW'(2 * BUFFER_DEPTH - 1);
  localparam logic [IW-1:0] DEPTH_I  = IW'(BUFFER_DEPTH);
  localparam logic [IW:0]   IDX_MOD  = (IW + 1)'(2 * BUFFER_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_KILL, S_READ} state_t;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] a);
    return (a == IDX_LAST) ? '0 : a + 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dec(input logic [IW-1:0] a);
    return (a == '0) ? IDX_LAST : a - 1'b1;
  endfunction

  function automatic logic [IW-1:0] idx_dist(input logic [IW-1:0] a,
                                             input logic [IW-1:0] b);
    logic [IW:0] d;
    d = {1'b0, a} - {1'b0, b};
    if (a < b) begin
      d = d + IDX_MOD;
    end
    return d[IW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot(input logic [IW-1:0] a);
    logic [IW-1:0] s;
    s = (a >= DEPTH_I) ? a - DEPTH_I : a;
    return s[AW-1:0];
  endfunction

  state_t        state_r, state_nxt;
  logic [IW-1:0] read_idx_r, read_idx_nxt;
  logic [IW-1:0] commit_idx_r, commit_idx_nxt;
  logic [IW-1:0] edit_idx_r, edit_idx_nxt;
  logic [9:0]    erase_n_r, erase_n_nxt;
  logic          started_r, started_nxt;

  logic          valid_r, valid_nxt;
  logic [1:0]    echo_kind_r, echo_kind_nxt;
  logic [7:0]    echo_byte_r, echo_byte_nxt;
  logic [9:0]    erase_count_r, erase_count_nxt;
  logic          read_valid_r, read_valid_nxt;
  logic [7:0]    read_byte_r, read_byte_nxt;
  logic          read_done_r, read_done_nxt;
  logic          line_ready_r, line_ready_nxt;
  logic          dump_r, dump_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic [IW-1:0] edit_dec, edit_dec2, edit_inc;
  logic [7:0]    rx_char;
  logic [9:0]    erase_n_inc;

  assign edit_dec    = idx_dec(edit_idx_r);
  assign edit_dec2   = idx_dec(edit_dec);
  assign edit_inc    = idx_inc(edit_idx_r);
  assign rx_char     = (in_rx_byte == CH_CR) ? CH_NL : in_rx_byte;
  assign erase_n_inc = (erase_n_r == ERASE_MAX) ? erase_n_r : erase_n_r + 10'd1;

  cle_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt       = state_r;
    read_idx_nxt    = read_idx_r;
    commit_idx_nxt  = commit_idx_r;
    edit_idx_nxt    = edit_idx_r;
    erase_n_nxt     = erase_n_r;
    started_nxt     = started_r;
    valid_nxt       = 1'b0;
    echo_kind_nxt   = echo_kind_r;
    echo_byte_nxt   = echo_byte_r;
    erase_count_nxt = erase_count_r;
    read_valid_nxt  = read_valid_r;
    read_byte_nxt   = read_byte_r;
    read_done_nxt   = read_done_r;
    line_ready_nxt  = line_ready_r;
    dump_nxt        = dump_r;
    ram_we          = 1'b0;
    ram_waddr       = slot(edit_idx_r);
    ram_wdata       = rx_char;
    ram_raddr       = slot(edit_dec);

    case (state_r)
      S_IDLE: begin
        if (start) begin
          echo_kind_nxt   = ECHO_NONE;
          echo_byte_nxt   = '0;
          erase_count_nxt = '0;
          read_valid_nxt  = 1'b0;
          read_byte_nxt   = '0;
          read_done_nxt   = 1'b0;
          line_ready_nxt  = 1'b0;
          dump_nxt        = 1'b0;
          valid_nxt       = 1'b1;
          if (in_operation == OP_RX) begin
            if (in_rx_byte == CH_CTLP) begin
              dump_nxt = 1'b1;
            end else if (in_rx_byte == CH_CTLU) begin
              erase_n_nxt = '0;
              if (edit_idx_r != commit_idx_r) begin
                valid_nxt = 1'b0;
                state_nxt = S_KILL;
              end
            end else if (in_rx_byte == CH_CTLH || in_rx_byte == CH_DEL) begin
              if (edit_idx_r != commit_idx_r) begin
                edit_idx_nxt    = edit_dec;
                echo_kind_nxt   = ECHO_ERASE;
                erase_count_nxt = 10'd1;
              end
            end else if (in_rx_byte != CH_NUL &&
                         idx_dist(edit_idx_r, read_idx_r) < DEPTH_I) begin
              ram_we        = 1'b1;
              edit_idx_nxt  = edit_inc;
              echo_kind_nxt = ECHO_BYTE;
              echo_byte_nxt = rx_char;
              if (rx_char == CH_NL || rx_char == CH_CTLD ||
                  idx_dist(edit_inc, read_idx_r) == DEPTH_I) begin
                commit_idx_nxt = edit_inc;
                line_ready_nxt = 1'b1;
              end
            end
          end else begin
            ram_raddr = slot(read_idx_r);
            if (read_idx_r != commit_idx_r) begin
              started_nxt = in_read_started;
              valid_nxt   = 1'b0;
              state_nxt   = S_READ;
            end
          end
        end
      end

      S_KILL: begin
        ram_raddr = slot(edit_dec2);
        if (ram_rdata == CH_NL) begin
          valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          edit_idx_nxt = edit_dec;
          erase_n_nxt  = erase_n_inc;
          if (edit_dec == commit_idx_r) begin
            valid_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
        if (valid_nxt && erase_n_nxt != '0) begin
          echo_kind_nxt   = ECHO_ERASE;
          erase_count_nxt = erase_n_nxt;
        end
      end

      S_READ: begin
        valid_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (ram_rdata == CH_CTLD) begin
          read_done_nxt = 1'b1;
          if (!started_r) begin
            read_idx_nxt = idx_inc(read_idx_r);
          end
        end else begin
          read_idx_nxt   = idx_inc(read_idx_r);
          read_valid_nxt = 1'b1;
          read_byte_nxt  = ram_rdata;
          read_done_nxt  = (ram_rdata == CH_NL);
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      read_idx_r   <= '0;
      commit_idx_r <= '0;
      edit_idx_r   <= '0;
      valid_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      read_idx_r   <= read_idx_nxt;
      commit_idx_r <= commit_idx_nxt;
      edit_idx_r   <= edit_idx_nxt;
      valid_r      <= valid_nxt;
    end
    erase_n_r     <= erase_n_nxt;
    started_r     <= started_nxt;
    echo_kind_r   <= echo_kind_nxt;
    echo_byte_r   <= echo_byte_nxt;
    erase_count_r <= erase_count_nxt;
    read_valid_r  <= read_valid_nxt;
    read_byte_r   <= read_byte_nxt;
    read_done_r   <= read_done_nxt;
    line_ready_r  <= line_ready_nxt;
    dump_r        <= dump_nxt;
  end

  assign busy             = (state_r != S_IDLE);
  assign out_valid        = valid_r;
  assign out_echo_kind    = echo_kind_r;
  assign out_echo_byte    = echo_byte_r;
  assign out_erase_count  = erase_count_r;
  assign out_read_valid   = read_valid_r;
  assign out_read_byte    = read_byte_r;
  assign out_read_done    = read_done_r;
  assign out_line_ready   = line_ready_r;
  assign out_dump_request = dump_r;

endmodule

[hdl/cle_ram.sv]
// cle_ram: generic single write port, single read port ram
// read data registered from the read address; no dependencies
module cle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[test/console_line_editor_checker.sv]
// console_line_editor_checker: predicts and checks every console line editor reply
// watches the start/busy and out_valid channels; depends on cle_pkg
module console_line_editor_checker #(
  parameter int BUFFER_DEPTH = 512
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_operation,
  input  logic [7:0] in_rx_byte,
  input  logic       in_read_started,
  input  logic       out_valid,
  input  logic [1:0] out_echo_kind,
  input  logic [7:0] out_echo_byte,
  input  logic [9:0] out_erase_count,
  input  logic       out_read_valid,
  input  logic [7:0] out_read_byte,
  input  logic       out_read_done,
  input  logic       out_line_ready,
  input  logic       out_dump_request,
  output int         fail_count,
  output int         awaited
);
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  localparam int IW = $clog2(BUFFER_DEPTH) + 1;

  typedef struct packed {
    logic [1:0] echo_kind;
    logic [7:0] echo_byte;
    logic [9:0] erase_count;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       read_done;
    logic       line_ready;
    logic       dump_request;
  } reply_t;

  reply_t awaited_replies[$];

  logic [7:0]    ring [BUFFER_DEPTH];
  logic [IW-1:0] rd_ptr;
  logic [IW-1:0] cm_ptr;
  logic [IW-1:0] ed_ptr;

  task automatic run_line_discipline(input logic op, input logic [7:0] ch,
                                     input logic started, output reply_t r);
    logic [IW-1:0] prev;
    logic [IW-1:0] span;
    logic [7:0]    b;
    int            n;
    r = '0;
    if (op == OP_RX) begin
      span = ed_ptr - rd_ptr;
      if (ch == CH_CTLP) begin
        r.dump_request = 1'b1;
      end else if (ch == CH_CTLU) begin
        n = 0;
        prev = ed_ptr - 1'b1;
        while (ed_ptr != cm_ptr && ring[prev[IW-2:0]] != CH_NL) begin
          ed_ptr = prev;
          prev = ed_ptr - 1'b1;
          n++;
        end
        if (n > 0) begin
          r.echo_kind = ECHO_ERASE;
          r.erase_count = (n > ERASE_MAX) ? ERASE_MAX : 10'(n);
        end
      end else if (ch == CH_CTLH || ch == CH_DEL) begin
        if (ed_ptr != cm_ptr) begin
          ed_ptr = ed_ptr - 1'b1;
          r.echo_kind = ECHO_ERASE;
          r.erase_count = 10'd1;
        end
      end else if (ch != CH_NUL && span < BUFFER_DEPTH) begin
        b = (ch == CH_CR) ? CH_NL : ch;
        ring[ed_ptr[IW-2:0]] = b;
        ed_ptr = ed_ptr + 1'b1;
        span = ed_ptr - rd_ptr;
        r.echo_kind = ECHO_BYTE;
        r.echo_byte = b;
        if (b == CH_NL || b == CH_CTLD || span == BUFFER_DEPTH) begin
          cm_ptr = ed_ptr;
          r.line_ready = 1'b1;
        end
      end
    end else if (rd_ptr != cm_ptr) begin
      b = ring[rd_ptr[IW-2:0]];
      if (b == CH_CTLD) begin
        // end of file stays put when the read already delivered bytes
        if (!started) rd_ptr = rd_ptr + 1'b1;
        r.read_done = 1'b1;
      end else begin
        rd_ptr = rd_ptr + 1'b1;
        r.read_valid = 1'b1;
        r.read_byte = b;
        r.read_done = (b == CH_NL);
      end
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    reply_t r;
    if (!rst_n) begin
      rd_ptr = '0;
      cm_ptr = '0;
      ed_ptr = '0;
      awaited_replies.delete();
    end else begin
      if (start && !busy) begin
        run_line_discipline(in_operation, in_rx_byte, in_read_started, r);
        awaited_replies.push_back(r);
      end
      if (out_valid) begin
        if (awaited_replies.size() == 0) begin
          $error("result transfer with no item outstanding");
          fail_count++;
        end else begin
          r = awaited_replies.pop_front();
          check_field("echo_kind", 32'(r.echo_kind), 32'(out_echo_kind));
          check_field("echo_byte", 32'(r.echo_byte), 32'(out_echo_byte));
          check_field("erase_count", 32'(r.erase_count), 32'(out_erase_count));
          check_field("read_valid", 32'(r.read_valid), 32'(out_read_valid));
          check_field("read_byte", 32'(r.read_byte), 32'(out_read_byte));
          check_field("read_done", 32'(r.read_done), 32'(out_read_done));
          check_field("line_ready", 32'(r.line_ready), 32'(out_line_ready));
          check_field("dump_request", 32'(r.dump_request), 32'(out_dump_request));
        end
      end
    end
    awaited <= awaited_replies.size();
  end

endmodule

[test/console_line_editor_unit_tb.sv]
// console_line_editor_unit_tb: drives keystrokes and reads into the line editor
// depends on cle_pkg, console_line_editor_unit and console_line_editor_checker
module console_line_editor_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cle_pkg::*;

  localparam int LIMIT  = 4_000_000;
  localparam int SETTLE = 520;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_operation = OP_RX;
  logic [7:0] in_rx_byte = CH_NUL;
  logic       in_read_started = 1'b0;
  logic       out_valid;
  logic [1:0] out_echo_kind;
  logic [7:0] out_echo_byte;
  logic [9:0] out_erase_count;
  logic       out_read_valid;
  logic [7:0] out_read_byte;
  logic       out_read_done;
  logic       out_line_ready;
  logic       out_dump_request;

  int fail_count;
  int awaited;
  int cycles = 0;
  int sent = 0;
  int idle_pct = 10;

  always #6 clk = ~clk;

  console_line_editor_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_rx_byte      (in_rx_byte),
    .in_read_started (in_read_started),
    .out_valid       (out_valid),
    .out_echo_kind   (out_echo_kind),
    .out_echo_byte   (out_echo_byte),
    .out_erase_count (out_erase_count),
    .out_read_valid  (out_read_valid),
    .out_read_byte   (out_read_byte),
    .out_read_done   (out_read_done),
    .out_line_ready  (out_line_ready),
    .out_dump_request(out_dump_request)
  );

  console_line_editor_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_rx_byte      (in_rx_byte),
    .in_read_started (in_read_started),
    .out_valid       (out_valid),
    .out_echo_kind   (out_echo_kind),
    .out_echo_byte   (out_echo_byte),
    .out_erase_count (out_erase_count),
    .out_read_valid  (out_read_valid),
    .out_read_byte   (out_read_byte),
    .out_read_done   (out_read_done),
    .out_line_ready  (out_line_ready),
    .out_dump_request(out_dump_request),
    .fail_count      (fail_count),
    .awaited         (awaited)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(input logic op, input logic [7:0] ch, input logic started);
    int gap;
    gap = 0;
    if ($urandom_range(99) < idle_pct) gap = $urandom_range(1, 3);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_operation <= op;
    in_rx_byte <= ch;
    in_read_started <= started;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic read_bytes(input int cnt);
    repeat (cnt) send_request(OP_READ, 8'($urandom_range(255)), $urandom_range(99) < 30);
  endtask

  task automatic type_line(input int len);
    int pick;
    repeat (len) begin
      pick = $urandom_range(99);
      if (pick < 8) send_request(OP_RX, pick[0] ? CH_CTLH : CH_DEL, 1'($urandom_range(1)));
      else if (pick < 10) send_request(OP_RX, CH_CTLU, 1'($urandom_range(1)));
      else if (pick < 12) send_request(OP_RX, CH_CTLP, 1'($urandom_range(1)));
      else if (pick < 13) send_request(OP_RX, CH_NUL, 1'($urandom_range(1)));
      else send_request(OP_RX, 8'($urandom_range(8'h20, 8'hff)), 1'($urandom_range(1)));
    end
    pick = $urandom_range(99);
    if (pick < 45) send_request(OP_RX, CH_NL, 1'($urandom_range(1)));
    else if (pick < 80) send_request(OP_RX, CH_CR, 1'($urandom_range(1)));
    else if (pick < 95) send_request(OP_RX, CH_CTLD, 1'($urandom_range(1)));
  endtask

  task automatic run_episodes(input int quota);
    int target;
    int len;
    target = sent + quota;
    while (sent < target) begin
      if ($urandom_range(99) < 82) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 16);
        type_line(len);
        read_bytes(len + $urandom_range(0, 6));
      end else begin
        // noise: any operation, any byte
        repeat ($urandom_range(5, 15))
          send_request(1'($urandom_range(1)), 8'($urandom_range(255)),
                       1'($urandom_range(1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty buffer, edits, carriage return, end of file on read
    send_request(OP_READ, CH_NUL, 1'b0);
    send_request(OP_RX, CH_CTLH, 1'b0);
    send_request(OP_RX, CH_DEL, 1'b1);
    send_request(OP_RX, CH_CTLU, 1'b0);
    send_request(OP_RX, CH_NUL, 1'b0);
    send_request(OP_RX, CH_CTLP, 1'b0);
    send_request(OP_RX, 8'hff, 1'b1);
    send_request(OP_RX, 8'h80, 1'b0);
    send_request(OP_RX, CH_DEL, 1'b0);
    send_request(OP_RX, 8'h41, 1'b0);
    send_request(OP_RX, CH_CTLH, 1'b0);
    send_request(OP_RX, 8'h01, 1'b0);
    send_request(OP_RX, 8'h7e, 1'b0);
    send_request(OP_RX, CH_CTLU, 1'b0);
    send_request(OP_RX, 8'h61, 1'b0);
    send_request(OP_RX, CH_CR, 1'b0);
    send_request(OP_RX, 8'h62, 1'b0);
    send_request(OP_RX, CH_CTLD, 1'b0);
    send_request(OP_RX, CH_CTLH, 1'b0);
    send_request(OP_READ, 8'hff, 1'b0);
    send_request(OP_READ, CH_NUL, 1'b1);
    send_request(OP_READ, CH_NUL, 1'b1);
    send_request(OP_READ, CH_NUL, 1'b1);
    send_request(OP_READ, CH_NUL, 1'b0);
    send_request(OP_READ, CH_NUL, 1'b0);

    // longest kill, then fill the ring until it commits and drops
    repeat (511) send_request(OP_RX, 8'($urandom_range(8'h20, 8'h7e)), 1'($urandom_range(1)));
    send_request(OP_RX, CH_CTLU, 1'b0);
    repeat (513) send_request(OP_RX, 8'($urandom_range(8'h20, 8'h7e)), 1'($urandom_range(1)));
    read_bytes(513);

    run_episodes(85);
    idle_pct = 51;
    run_episodes(85);
    idle_pct = 0;
    run_episodes(85);

    start <= 1'b0;
    do @(posedge clk); while (awaited != 0);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && awaited == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cle_pkg.sv
hdl/cle_ram.sv
hdl/console_line_editor_unit.sv
test/console_line_editor_checker.sv
test/console_line_editor_unit_tb.sv
